@@ hw/rtl/ssr_pkg.sv @@
`default_nettype none

package ssr_pkg;

  localparam int COORD_BITS = 10;
  localparam int RECT_W     = 12;
  localparam int ID_W       = 4;
  localparam int NUM_SLOTS  = 9;
  localparam int COLOUR_W   = 16;
  localparam int DIGIT_W    = 4;

  typedef logic [COORD_BITS-1:0]  coord_t;
  typedef logic signed [RECT_W-1:0] rect_coord_t;
  typedef logic [ID_W-1:0]        seg_id_t;
  typedef logic [NUM_SLOTS-1:0]   slot_mask_t;
  typedef logic [6:0]             seg7_t;
  typedef logic [COLOUR_W-1:0]    colour_t;
  typedef logic [DIGIT_W-1:0]     digit_t;

  // bit positions in the seven-segment pattern
  localparam int SEG_A = 0;
  localparam int SEG_B = 1;
  localparam int SEG_C = 2;
  localparam int SEG_D = 3;
  localparam int SEG_E = 4;
  localparam int SEG_F = 5;
  localparam int SEG_G = 6;

  // rectangle ids; emission order follows the id order
  localparam seg_id_t ID_A      = 4'd0;
  localparam seg_id_t ID_G      = 4'd1;
  localparam seg_id_t ID_D      = 4'd2;
  localparam seg_id_t ID_F      = 4'd3;
  localparam seg_id_t ID_E      = 4'd4;
  localparam seg_id_t ID_LFULL  = 4'd5;
  localparam seg_id_t ID_B      = 4'd6;
  localparam seg_id_t ID_C      = 4'd7;
  localparam seg_id_t ID_RFULL  = 4'd8;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
    coord_t t;
    seg7_t  seg;
  } cell_t;

  typedef struct packed {
    rect_coord_t x;
    rect_coord_t y;
    rect_coord_t w;
    rect_coord_t h;
  } rect_t;

  function automatic seg7_t seg_lookup(input digit_t d);
    seg7_t s;
    unique case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  function automatic rect_coord_t to_rect(input coord_t v);
    return rect_coord_t'(v);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ssr_decode.sv @@
`default_nettype none

module ssr_decode (
  input  wire ssr_pkg::digit_t     digit,
  output ssr_pkg::seg7_t           seg,
  output ssr_pkg::slot_mask_t      mask
);

  logic l_full;
  logic r_full;

  assign seg = ssr_pkg::seg_lookup(digit);

  // without the middle bar a fully lit side is drawn as one stroke
  assign l_full = !seg[ssr_pkg::SEG_G] && seg[ssr_pkg::SEG_F] && seg[ssr_pkg::SEG_E];
  assign r_full = !seg[ssr_pkg::SEG_G] && seg[ssr_pkg::SEG_B] && seg[ssr_pkg::SEG_C];

  always_comb begin
    mask = '0;
    mask[ssr_pkg::ID_A]     = seg[ssr_pkg::SEG_A];
    mask[ssr_pkg::ID_G]     = seg[ssr_pkg::SEG_G];
    mask[ssr_pkg::ID_D]     = seg[ssr_pkg::SEG_D];
    mask[ssr_pkg::ID_F]     = seg[ssr_pkg::SEG_F] && !l_full;
    mask[ssr_pkg::ID_E]     = seg[ssr_pkg::SEG_E] && !l_full;
    mask[ssr_pkg::ID_LFULL] = l_full;
    mask[ssr_pkg::ID_B]     = seg[ssr_pkg::SEG_B] && !r_full;
    mask[ssr_pkg::ID_C]     = seg[ssr_pkg::SEG_C] && !r_full;
    mask[ssr_pkg::ID_RFULL] = r_full;
  end

endmodule

`default_nettype wire

@@ hw/rtl/ssr_geom.sv @@
`default_nettype none

module ssr_geom (
  input  wire ssr_pkg::cell_t    shape,
  input  wire ssr_pkg::seg_id_t  id,
  output ssr_pkg::rect_t         rect
);

  ssr_pkg::rect_coord_t x, y, w, h, t;
  ssr_pkg::rect_coord_t mid_y, top_y, top_h, bot_y, bot_h, bot_end, full_h;
  ssr_pkg::rect_coord_t d_y, right_x;

  // all arithmetic wraps at the 12-bit output width
  assign x = ssr_pkg::to_rect(shape.x);
  assign y = ssr_pkg::to_rect(shape.y);
  assign w = ssr_pkg::to_rect(shape.w);
  assign h = ssr_pkg::to_rect(shape.h);
  assign t = ssr_pkg::to_rect(shape.t);

  assign mid_y   = y + ssr_pkg::to_rect(shape.h >> 1) - ssr_pkg::to_rect(shape.t >> 1);
  assign top_y   = shape.seg[ssr_pkg::SEG_A] ? (y + t) : y;
  assign top_h   = mid_y - top_y;
  assign bot_y   = mid_y + t;
  assign d_y     = y + h - t;
  assign bot_end = shape.seg[ssr_pkg::SEG_D] ? d_y : (y + h);
  assign bot_h   = bot_end - bot_y;
  assign full_h  = bot_end - top_y;
  assign right_x = x + w - t;

  always_comb begin
    unique case (id)
      ssr_pkg::ID_A:     rect = '{x: x,       y: y,     w: w, h: t};
      ssr_pkg::ID_G:     rect = '{x: x,       y: mid_y, w: w, h: t};
      ssr_pkg::ID_D:     rect = '{x: x,       y: d_y,   w: w, h: t};
      ssr_pkg::ID_F:     rect = '{x: x,       y: top_y, w: t, h: top_h};
      ssr_pkg::ID_E:     rect = '{x: x,       y: bot_y, w: t, h: bot_h};
      ssr_pkg::ID_LFULL: rect = '{x: x,       y: top_y, w: t, h: full_h};
      ssr_pkg::ID_B:     rect = '{x: right_x, y: top_y, w: t, h: top_h};
      ssr_pkg::ID_C:     rect = '{x: right_x, y: bot_y, w: t, h: bot_h};
      ssr_pkg::ID_RFULL: rect = '{x: right_x, y: top_y, w: t, h: full_h};
      default:           rect = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/seven_segment_rect_generator.sv @@
// Seven-segment rectangle generator.
// A digit request (cell origin, size, stroke, digit, colour) is taken at a
// rising edge where start is high and busy is low. For each lit segment one
// rectangle word leaves on the out_ ports for exactly one cycle, flagged by
// out_strobe, in the order a, g, d, left side, right side; out_last marks the
// final word of a digit. Digits 10 to 15 produce no words.
// An accepted request is stored in the pending mask and cell registers;
// each word is then registered into the out_ registers. Words of one
// digit follow back to back, one per cycle. A digit has at most 7
// rectangles; busy drops while the last word of the current digit is
// picked from the pending set, so the next digit's first word follows with
// no gap. The rate is set by the single rectangle output port.
// Reset (synchronous, rst_n low) drops all pending words and the strobe.
// The receiver cannot stall: every strobed word is taken in its cycle.
`default_nettype none

module seven_segment_rect_generator (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  output logic                        busy,
  input  wire ssr_pkg::coord_t        in_cell_x,
  input  wire ssr_pkg::coord_t        in_cell_y,
  input  wire ssr_pkg::coord_t        in_cell_width,
  input  wire ssr_pkg::coord_t        in_cell_height,
  input  wire ssr_pkg::coord_t        in_stroke,
  input  wire ssr_pkg::digit_t        in_digit,
  input  wire ssr_pkg::colour_t       in_colour,
  output logic                        out_strobe,
  output ssr_pkg::rect_coord_t        out_rect_x,
  output ssr_pkg::rect_coord_t        out_rect_y,
  output ssr_pkg::rect_coord_t        out_rect_w,
  output ssr_pkg::rect_coord_t        out_rect_h,
  output ssr_pkg::colour_t            out_rect_colour,
  output ssr_pkg::seg_id_t            out_segment_id,
  output logic                        out_last
);

  ssr_pkg::seg7_t      new_seg;
  ssr_pkg::slot_mask_t new_mask;

  ssr_pkg::cell_t      cell_r, cell_nxt;
  ssr_pkg::colour_t    colour_r, colour_nxt;
  ssr_pkg::slot_mask_t pend_r, pend_nxt;

  ssr_pkg::slot_mask_t pick;
  ssr_pkg::slot_mask_t rest;
  ssr_pkg::seg_id_t    pick_id;
  ssr_pkg::rect_t      rect;
  logic                accept;

  logic                strobe_r, strobe_nxt;
  logic                last_r, last_nxt;
  ssr_pkg::rect_t      rect_r, rect_nxt;
  ssr_pkg::colour_t    ocol_r, ocol_nxt;
  ssr_pkg::seg_id_t    id_r, id_nxt;

  ssr_decode u_decode (
    .digit (in_digit),
    .seg   (new_seg),
    .mask  (new_mask)
  );

  // lowest pending slot goes out first
  assign pick = pend_r & (~pend_r + ssr_pkg::slot_mask_t'(1));
  assign rest = pend_r & ~pick;

  always_comb begin
    pick_id = '0;
    for (int i = 0; i < ssr_pkg::NUM_SLOTS; i++) begin
      if (pick[i]) begin
        pick_id = pick_id | ssr_pkg::seg_id_t'(i);
      end
    end
  end

  ssr_geom u_geom (
    .shape (cell_r),
    .id    (pick_id),
    .rect  (rect)
  );

  // free once the word leaving now is the current digit's last
  assign busy   = |rest;
  assign accept = start && !busy;

  always_comb begin
    cell_nxt   = cell_r;
    colour_nxt = colour_r;
    pend_nxt   = rest;
    if (accept) begin
      cell_nxt   = '{x: in_cell_x, y: in_cell_y, w: in_cell_width,
                     h: in_cell_height, t: in_stroke, seg: new_seg};
      colour_nxt = in_colour;
      pend_nxt   = new_mask;
    end
  end

  assign strobe_nxt = |pend_r;
  assign last_nxt   = (rest == '0);
  assign rect_nxt   = rect;
  assign ocol_nxt   = colour_r;
  assign id_nxt     = pick_id;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= '0;
      strobe_r <= 1'b0;
    end else begin
      pend_r   <= pend_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cell_r   <= cell_nxt;
    colour_r <= colour_nxt;
    last_r   <= last_nxt;
    rect_r   <= rect_nxt;
    ocol_r   <= ocol_nxt;
    id_r     <= id_nxt;
  end

  assign out_strobe      = strobe_r;
  assign out_rect_x      = rect_r.x;
  assign out_rect_y      = rect_r.y;
  assign out_rect_w      = rect_r.w;
  assign out_rect_h      = rect_r.h;
  assign out_rect_colour = ocol_r;
  assign out_segment_id  = id_r;
  assign out_last        = last_r;

  a_pend_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r != '0) |=> strobe_r)
    else $error("pending rectangle not emitted");

  a_free_single: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> ($countones(pend_r) <= 1))
    else $error("accepting while several rectangles pending");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && !last_r) |-> (pend_r != '0))
    else $error("digit ended without last word");

  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (pend_r == $past(rest)))
    else $error("pending set changed while busy");

endmodule

`default_nettype wire
